/* design/spst_pkg.sv */
// shared types and constants for the sumset / product-set size tracker
// no dependencies; used by spst_ctrl, spst_dpath and the top module
`timescale 1ns / 1ps

package spst_pkg;

    // element range and field widths
    localparam int ELEM_W      = 6;
    localparam int MAX_ELEMENT = 63;
    localparam int NUM_ELEM    = 2 ** ELEM_W;
    localparam int SET_W       = 6;
    localparam int DSUM_W      = 7;
    localparam int DPROD_W     = 12;
    localparam int PSET_W      = 11;

    // pair counter tables
    localparam int SUM_DEPTH   = 2 * MAX_ELEMENT + 1;
    localparam int PROD_DEPTH  = MAX_ELEMENT * MAX_ELEMENT + 1;
    localparam int SUM_AW      = $clog2(SUM_DEPTH);
    localparam int PROD_AW     = $clog2(PROD_DEPTH);
    localparam int SUM_CNT_W   = 7;
    localparam int PROD_CNT_W  = 8;
    localparam int PAIR_DELTA  = 2;
    localparam int SELF_DELTA  = 1;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_USED_W  = 1 + SET_W + DSUM_W + PSET_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PAIR,
        S_SELF,
        S_DRAIN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clear_step;
        logic pair_step;
        logic self_step;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic elem_ok;
        logic last_y;
        logic clear_last;
        logic out_free;
    } t_stat;

endpackage

/* design/spst_ram.sv */
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module spst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/spst_ctrl.sv */
// sequencing state machine: clearing pass, partner scan, self term, result hand-off
// depends on spst_pkg
`timescale 1ns / 1ps

module spst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  spst_pkg::t_stat i_stat,
    output spst_pkg::t_cmd  o_cmd
);

    spst_pkg::t_state r_state;
    spst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spst_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spst_pkg::S_CLEAR: begin
                if (i_stat.clear_last) n_state = spst_pkg::S_IDLE;
            end
            spst_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_stat.elem_ok ? spst_pkg::S_PAIR : spst_pkg::S_DONE;
                end
            end
            spst_pkg::S_PAIR: begin
                if (i_stat.last_y) n_state = spst_pkg::S_SELF;
            end
            spst_pkg::S_SELF:  n_state = spst_pkg::S_DRAIN;
            spst_pkg::S_DRAIN: n_state = spst_pkg::S_DONE;
            spst_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = spst_pkg::S_IDLE;
            end
            default: n_state = spst_pkg::S_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            spst_pkg::S_CLEAR: o_cmd.clear_step = 1'b1;
            spst_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            spst_pkg::S_PAIR:  o_cmd.pair_step = 1'b1;
            spst_pkg::S_SELF:  o_cmd.self_step = 1'b1;
            spst_pkg::S_DRAIN: o_cmd = '0;
            spst_pkg::S_DONE:  o_cmd.commit = i_stat.out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule

/* design/spst_dpath.sv */
// datapath: membership bits, pair counter rams with read-modify-write pipe,
// distinct-value counters and the output register; depends on spst_pkg, spst_ram
`timescale 1ns / 1ps

module spst_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spst_pkg::t_cmd                      i_cmd,
    output spst_pkg::t_stat                     o_stat,
    input  logic [spst_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [spst_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    logic [spst_pkg::ELEM_W-1:0]   w_elem;
    logic [spst_pkg::NUM_ELEM-1:0] r_member;
    logic [spst_pkg::NUM_ELEM-1:0] n_member;
    logic [spst_pkg::ELEM_W-1:0]   r_x;
    logic                          r_up;
    logic                          r_active;
    logic [spst_pkg::ELEM_W-1:0]   r_y;
    logic [spst_pkg::PROD_AW-1:0]  r_clr;
    logic [spst_pkg::SET_W-1:0]    r_set_size;
    logic [spst_pkg::SET_W-1:0]    n_set_size;
    logic [spst_pkg::DSUM_W-1:0]   r_dsum;
    logic [spst_pkg::DSUM_W-1:0]   n_dsum;
    logic [spst_pkg::DPROD_W-1:0]  r_dprod;
    logic [spst_pkg::DPROD_W-1:0]  n_dprod;

    // issue stage
    logic                          w_issue;
    logic [spst_pkg::ELEM_W-1:0]   w_partner;
    logic [spst_pkg::ELEM_W:0]     w_sum;
    logic [2*spst_pkg::ELEM_W-1:0] w_prod;
    logic [spst_pkg::SUM_AW-1:0]   w_saddr;
    logic [spst_pkg::PROD_AW-1:0]  w_paddr;

    // update stage
    logic                          r_s2_valid;
    logic                          r_s2_self;
    logic [spst_pkg::SUM_AW-1:0]   r_s2_saddr;
    logic [spst_pkg::PROD_AW-1:0]  r_s2_paddr;
    logic [spst_pkg::SUM_CNT_W-1:0]  w_sum_old;
    logic [spst_pkg::SUM_CNT_W-1:0]  w_sum_new;
    logic [spst_pkg::SUM_CNT_W-1:0]  w_sum_delta;
    logic [spst_pkg::PROD_CNT_W-1:0] w_prod_old;
    logic [spst_pkg::PROD_CNT_W-1:0] w_prod_new;
    logic [spst_pkg::PROD_CNT_W-1:0] w_prod_delta;

    // ram write ports, shared with the clearing pass
    logic                            w_sum_we;
    logic [spst_pkg::SUM_AW-1:0]     w_sum_waddr;
    logic [spst_pkg::SUM_CNT_W-1:0]  w_sum_wdata;
    logic                            w_prod_we;
    logic [spst_pkg::PROD_AW-1:0]    w_prod_waddr;
    logic [spst_pkg::PROD_CNT_W-1:0] w_prod_wdata;

    // output register
    logic                                r_out_valid;
    logic [spst_pkg::OUT_TDATA_W-1:0]    r_out_data;

    assign w_elem = i_s_tdata[spst_pkg::ELEM_W-1:0];

    assign o_stat.elem_ok    = (w_elem != '0) &&
                               (w_elem <= spst_pkg::ELEM_W'(spst_pkg::MAX_ELEMENT));
    assign o_stat.last_y     = (r_y == spst_pkg::ELEM_W'(spst_pkg::MAX_ELEMENT));
    assign o_stat.clear_last = (r_clr == spst_pkg::PROD_AW'(spst_pkg::PROD_DEPTH - 1));
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    // the toggled element itself is skipped in the partner scan
    assign w_partner = i_cmd.self_step ? r_x : r_y;
    assign w_issue   = i_cmd.self_step ||
                       (i_cmd.pair_step && r_member[r_y] && (r_y != r_x));
    assign w_sum     = r_x + w_partner;
    assign w_prod    = r_x * w_partner;
    assign w_saddr   = spst_pkg::SUM_AW'(w_sum);
    assign w_paddr   = spst_pkg::PROD_AW'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= w_issue;
        end
        r_s2_self  <= i_cmd.self_step;
        r_s2_saddr <= w_saddr;
        r_s2_paddr <= w_paddr;
    end

    // counter update
    assign w_sum_delta  = r_s2_self ? spst_pkg::SUM_CNT_W'(spst_pkg::SELF_DELTA)
                                    : spst_pkg::SUM_CNT_W'(spst_pkg::PAIR_DELTA);
    assign w_prod_delta = r_s2_self ? spst_pkg::PROD_CNT_W'(spst_pkg::SELF_DELTA)
                                    : spst_pkg::PROD_CNT_W'(spst_pkg::PAIR_DELTA);
    assign w_sum_new    = r_up ? w_sum_old + w_sum_delta : w_sum_old - w_sum_delta;
    assign w_prod_new   = r_up ? w_prod_old + w_prod_delta : w_prod_old - w_prod_delta;

    always_comb begin
        n_dsum  = r_dsum;
        n_dprod = r_dprod;
        if (r_s2_valid) begin
            if (w_sum_old == '0 && w_sum_new != '0) begin
                n_dsum = r_dsum + spst_pkg::DSUM_W'(1);
            end else if (w_sum_old != '0 && w_sum_new == '0) begin
                n_dsum = r_dsum - spst_pkg::DSUM_W'(1);
            end
            if (w_prod_old == '0 && w_prod_new != '0) begin
                n_dprod = r_dprod + spst_pkg::DPROD_W'(1);
            end else if (w_prod_old != '0 && w_prod_new == '0) begin
                n_dprod = r_dprod - spst_pkg::DPROD_W'(1);
            end
        end
    end

    always_comb begin
        if (i_cmd.clear_step) begin
            w_sum_we     = (r_clr < spst_pkg::PROD_AW'(spst_pkg::SUM_DEPTH));
            w_sum_waddr  = r_clr[spst_pkg::SUM_AW-1:0];
            w_sum_wdata  = '0;
            w_prod_we    = 1'b1;
            w_prod_waddr = r_clr;
            w_prod_wdata = '0;
        end else begin
            w_sum_we     = r_s2_valid;
            w_sum_waddr  = r_s2_saddr;
            w_sum_wdata  = w_sum_new;
            w_prod_we    = r_s2_valid;
            w_prod_waddr = r_s2_paddr;
            w_prod_wdata = w_prod_new;
        end
    end

    spst_ram #(
        .WIDTH (spst_pkg::SUM_CNT_W),
        .DEPTH (spst_pkg::SUM_DEPTH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (w_sum_waddr),
        .i_wdata (w_sum_wdata),
        .i_raddr (w_saddr),
        .o_rdata (w_sum_old)
    );

    spst_ram #(
        .WIDTH (spst_pkg::PROD_CNT_W),
        .DEPTH (spst_pkg::PROD_DEPTH)
    ) u_prod_ram (
        .i_clk   (i_clk),
        .i_we    (w_prod_we),
        .i_waddr (w_prod_waddr),
        .i_wdata (w_prod_wdata),
        .i_raddr (w_paddr),
        .o_rdata (w_prod_old)
    );

    // membership and set size change only when the result is handed off
    always_comb begin
        n_member   = r_member;
        n_set_size = r_set_size;
        if (r_active) begin
            n_member[r_x] = r_up;
            n_set_size    = r_up ? r_set_size + spst_pkg::SET_W'(1)
                                 : r_set_size - spst_pkg::SET_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member    <= '0;
            r_set_size  <= '0;
            r_dsum      <= '0;
            r_dprod     <= '0;
            r_clr       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dsum  <= n_dsum;
            r_dprod <= n_dprod;
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + spst_pkg::PROD_AW'(1);
            end
            if (i_cmd.load) begin
                r_active <= o_stat.elem_ok;
            end
            if (i_cmd.commit) begin
                r_member    <= n_member;
                r_set_size  <= n_set_size;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= w_elem;
            r_up <= !r_member[w_elem];
            r_y  <= spst_pkg::ELEM_W'(1);
        end else if (i_cmd.pair_step) begin
            r_y  <= r_y + spst_pkg::ELEM_W'(1);
        end
        if (i_cmd.commit) begin
            r_out_data <= {{spst_pkg::OUT_PAD_W{1'b0}},
                           r_dprod[spst_pkg::PSET_W-1:0],
                           r_dsum,
                           n_set_size,
                           r_active & r_up};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_no_clear_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_step && r_s2_valid))
        else $error("counter update during clearing pass");

    a_set_size_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_member) == int'(r_set_size))
        else $error("set size differs from membership population");

    a_zero_never_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_member[0])
        else $error("element zero entered the set");

    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before it was taken");

endmodule

/* design/sumset_productset_size_tracker.sv */
// an in-range element is handled in these steps after the request is taken: load,
// a scan over every possible partner 1..63, self term, write drain, then hand-off;
// an element of zero goes straight from the request to the hand-off. a new request is
// taken only once the previous result has been handed off to the output register.
// reset: synchronous active-low; afterwards a clearing pass zeroes both counter rams
// while s_tready stays low, then the set starts empty.
`timescale 1ns / 1ps

module sumset_productset_size_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [spst_pkg::IN_TDATA_W-1:0]    s_tdata,   // [5:0] element, rest zero
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spst_pkg::OUT_TDATA_W-1:0]   m_tdata    // [0] was_added, [6:1] set_size,
                                                          // [13:7] sumset_size,
                                                          // [24:14] productset_size
);

    // control and status between the state machine and the datapath
    spst_pkg::t_cmd  w_cmd;
    spst_pkg::t_stat w_stat;

    // state machine: clear pass, then idle / scan / self / drain / hand-off
    spst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: membership bits, counter rams, distinct counts, result register
    spst_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule
